### sv/ddo_pkg.sv
// Shared types, register codes and fixed constants of the odometry block.
package ddo_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int INTERVAL_W  = 24;
   localparam int QUOT_W      = 31;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_METRES_PER_TICK = 3'd0;
   localparam csr_index_type CSR_INV_WHEEL_BASE  = 3'd1;
   localparam csr_index_type CSR_LEFT_NEG        = 3'd2;
   localparam csr_index_type CSR_RIGHT_NEG       = 3'd3;
   localparam csr_index_type CSR_MAX_INTERVAL    = 3'd4;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_BASELINE = 2'd0;
   localparam status_type STATUS_UPDATED  = 2'd1;
   localparam status_type STATUS_REJECTED = 2'd2;

   localparam logic [31:0] RST_METRES_PER_TICK = 32'd2725866;
   localparam logic [23:0] RST_INV_WHEEL_BASE  = 24'd312076;
   localparam logic [23:0] RST_MAX_INTERVAL    = 24'd1000000;

   // heading scale: 2^32 / (2 pi), full and half step
   localparam logic [31:0] ANG_SCALE = 32'd683565276;
   localparam logic [31:0] ANG_HALF  = 32'd341782638;
   localparam logic [31:0] US_PER_S  = 32'd1000000;
   localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

   localparam logic [31:0] ATAN_TABLE [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CALC   = 5'b00010,
      ST_CORDIC = 5'b00100,
      ST_DIV    = 5'b01000,
      ST_OUT    = 5'b10000
   } state_type;

endpackage

### sv/ddo_if.sv
// Valid/ready channel interfaces for readings and pose results.
interface ddo_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] left_count;
   logic signed [31:0] right_count;
   logic        [23:0] interval_us;

   modport source (output valid, left_count, right_count, interval_us, input ready);
   modport sink   (input valid, left_count, right_count, interval_us, output ready);
endinterface

interface ddo_rsp_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  status;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic        [31:0] heading_angle;
   logic signed [31:0] linear_velocity;
   logic signed [31:0] angular_velocity;

   modport source (output valid, status, pos_x, pos_y, heading_angle, linear_velocity,
                   angular_velocity, input ready);
   modport sink   (input valid, status, pos_x, pos_y, heading_angle, linear_velocity,
                   angular_velocity, output ready);
endinterface

### sv/ddo_cordic.sv
// Iterative CORDIC rotation: cosine and sine of a binary angle, one step a cycle.
module ddo_cordic #(
   parameter int STEPS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic        [31:0] angle,
   output logic               done,
   output logic signed [32:0] cos_out,
   output logic signed [32:0] sin_out
);
   import ddo_pkg::*;

   localparam int IW = $clog2(STEPS);

   logic signed [32:0] x_ff, y_ff;
   logic signed [33:0] z_ff;
   logic               flip_ff;
   logic [IW-1:0]      cnt_ff;
   logic               busy_ff, done_ff;

   logic signed [33:0] z_start;
   logic               flip_start;
   logic signed [32:0] x_sh, y_sh;
   logic signed [33:0] atan_val;

   always_comb begin
      z_start    = 34'(signed'(angle));
      flip_start = 1'b0;
      // fold beyond +-90 degrees by a half turn
      if (z_start > 34'sh040000000) begin
         z_start    = z_start - 34'sh080000000;
         flip_start = 1'b1;
      end else if (z_start < -34'sh040000000) begin
         z_start    = z_start + 34'sh080000000;
         flip_start = 1'b1;
      end
      x_sh     = x_ff >>> cnt_ff;
      y_sh     = y_ff >>> cnt_ff;
      atan_val = $signed({2'b00, ATAN_TABLE[5'(cnt_ff)]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == IW'(STEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= CORDIC_GAIN;
         y_ff    <= '0;
         z_ff    <= z_start;
         flip_ff <= flip_start;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_ff <= x_ff - y_sh;
            y_ff <= y_ff + x_sh;
            z_ff <= z_ff - atan_val;
         end else begin
            x_ff <= x_ff + y_sh;
            y_ff <= y_ff - x_sh;
            z_ff <= z_ff + atan_val;
         end
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign done    = done_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;

endmodule

### sv/ddo_div.sv
// Restoring divider: 31 quotient bits, one per cycle, with overflow detect.
module ddo_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [63:0]                     dividend,
   input  logic [ddo_pkg::INTERVAL_W-1:0]  divisor,
   output logic                            done,
   output logic                            overflow,
   output logic [ddo_pkg::QUOT_W-1:0]      quotient
);
   import ddo_pkg::*;

   logic [INTERVAL_W-1:0] rem_ff;
   logic [QUOT_W-1:0]     bits_ff, quot_ff;
   logic [4:0]            cnt_ff;
   logic                  busy_ff, done_ff, ovf_ff;

   logic [32:0]           top_part;
   logic                  ovf_start;
   logic [INTERVAL_W:0]   trial, trial_sub;
   logic                  ge;

   always_comb begin
      top_part  = dividend[63:QUOT_W];
      ovf_start = top_part >= 33'(divisor);
      trial     = {rem_ff, bits_ff[QUOT_W-1]};
      ge        = trial >= {1'b0, divisor};
      trial_sub = trial - {1'b0, divisor};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= !ovf_start;
            done_ff <= ovf_start;
         end else if (busy_ff && cnt_ff == 5'd1) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ovf_ff  <= ovf_start;
         rem_ff  <= top_part[INTERVAL_W-1:0];
         bits_ff <= dividend[QUOT_W-1:0];
         quot_ff <= '0;
         cnt_ff  <= 5'(QUOT_W);
      end else if (busy_ff) begin
         rem_ff  <= ge ? trial_sub[INTERVAL_W-1:0] : trial[INTERVAL_W-1:0];
         quot_ff <= {quot_ff[QUOT_W-2:0], ge};
         bits_ff <= {bits_ff[QUOT_W-2:0], 1'b0};
         cnt_ff  <= cnt_ff - 5'd1;
      end
   end

   assign done     = done_ff;
   assign overflow = ovf_ff;
   assign quotient = quot_ff;

endmodule

### sv/differential_drive_odometry_unit.sv
// Differential-drive wheel odometry: sequencer, shared multiplier, CORDIC and divider.
//
//  channel  dir  handshake         beat contents
//  req_     in   valid/ready       left_count, right_count, interval_us
//  rsp_     out  valid/ready       status, pos_x, pos_y, heading_angle, velocities
//  csr_     in   write enable only register index, write data
//
// Baseline and rejected readings go from idle straight to the output state and then
// into the output register. A pose update gets there through 24 sequencer steps on one
// shared 33x32 multiplier, the CORDIC, two divisions (31 quotient bits each) and the
// output state.
// Synchronous reset restores register defaults and clears pose and baseline.
// req_ ready is high only while idle; a finished beat waits in the output
// register, and the next reading is taken while it waits.
module differential_drive_odometry_unit #(
   parameter int CORDIC_STEPS = 24,
   parameter int COUNT_WIDTH  = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   ddo_req_if.sink                            req_chan,
   ddo_rsp_if.source                          rsp_chan,
   input  logic                               csr_write_en,
   input  logic [ddo_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ddo_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ddo_pkg::*;

   typedef logic [4:0] seq_type;
   localparam seq_type SQ_ML = 5'd0,  SQ_MR = 5'd1,  SQ_DR = 5'd2,  SQ_SD = 5'd3;
   localparam seq_type SQ_R0 = 5'd4,  SQ_R1 = 5'd5,  SQ_W0 = 5'd6,  SQ_W1 = 5'd7;
   localparam seq_type SQ_WS = 5'd8,  SQ_A0 = 5'd9,  SQ_A1 = 5'd10, SQ_H0 = 5'd11;
   localparam seq_type SQ_H1 = 5'd12, SQ_HS = 5'd13, SQ_X0 = 5'd14, SQ_X1 = 5'd15;
   localparam seq_type SQ_XS = 5'd16, SQ_Y1 = 5'd17, SQ_YS = 5'd18, SQ_V1 = 5'd19;
   localparam seq_type SQ_VD = 5'd20, SQ_G0 = 5'd21, SQ_G1 = 5'd22, SQ_GD = 5'd23;

   // configuration
   logic [31:0]           mpt_ff;
   logic [23:0]           inv_base_ff;
   logic                  left_neg_ff, right_neg_ff;
   logic [INTERVAL_W-1:0] max_int_ff;

   // architectural state
   logic signed [32:0] left_base_ff, right_base_ff;
   logic               base_valid_ff;
   logic [31:0]        pose_x_ff, pose_y_ff, pose_h_ff;

   // sequencer
   state_type state_ff, state_in;
   seq_type   seq_ff, seq_in;

   // working registers
   logic signed [32:0]    lc_ff, rc_ff;
   logic [INTERVAL_W-1:0] int_ff;
   logic [64:0]           prod_ff, t0_ff;
   logic signed [49:0]    dl_ff, dr_ff;
   logic [49:0]           dmag_ff;
   logic                  dneg_ff;
   logic signed [50:0]    diff_ff;
   logic [58:0]           rmag_ff;
   logic                  rneg_ff;
   logic [63:0]           wide_ff;
   logic [31:0]           hstep_ff;
   logic [31:0]           lin_ff, ang_ff;
   status_type            status_ff;

   // output register
   logic       rsp_valid_ff;
   status_type out_status_ff;
   logic [31:0] out_x_ff, out_y_ff, out_h_ff, out_lin_ff, out_ang_ff;

   // submodule wiring
   logic               cordic_start, cordic_done;
   logic signed [32:0] cos_val, sin_val;
   logic               div_start, div_done, div_ovf;
   logic [QUOT_W-1:0]  div_quot;
   logic [63:0]        div_num;

   // combinational datapath
   logic signed [32:0] lc_in, rc_in;
   logic               reject;
   logic signed [33:0] dlt_l, dlt_r;
   logic [32:0]        mag_l, mag_r;
   logic [48:0]        rnd_dist;
   logic signed [49:0] dist_pos;
   logic signed [50:0] sum_s, diff_s;
   logic [50:0]        sum_mag, diff_mag;
   logic [31:0]        diff_hi32;
   logic [75:0]        rsum;
   logic [63:0]        asum;
   logic [31:0]        ang_val;
   logic [32:0]        cos_abs, sin_abs;
   logic [81:0]        msum;
   logic [51:0]        move_mag;
   logic               move_neg;
   logic signed [53:0] move_base, move_cand;
   logic [31:0]        move_res;
   logic [32:0]        mul_a;
   logic [31:0]        mul_b;
   logic               rate_big, rate_neg, rate_sat;
   logic [31:0]        rate_res;

   function automatic logic signed [32:0] correct_count(input logic [31:0] raw,
                                                        input logic negate);
      logic signed [32:0] ext;
      ext = 33'(signed'(raw[COUNT_WIDTH-1:0]));
      return negate ? -ext : ext;
   endfunction

   ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle   (pose_h_ff + ang_val),
      .done    (cordic_done),
      .cos_out (cos_val),
      .sin_out (sin_val)
   );

   ddo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (int_ff),
      .done     (div_done),
      .overflow (div_ovf),
      .quotient (div_quot)
   );

   always_comb begin
      lc_in  = correct_count(req_chan.left_count, left_neg_ff);
      rc_in  = correct_count(req_chan.right_count, right_neg_ff);
      reject = (req_chan.interval_us == '0) || (req_chan.interval_us > max_int_ff);

      dlt_l = 34'(lc_ff) - 34'(left_base_ff);
      dlt_r = 34'(rc_ff) - 34'(right_base_ff);
      mag_l = dlt_l[33] ? 33'(-dlt_l) : dlt_l[32:0];
      mag_r = dlt_r[33] ? 33'(-dlt_r) : dlt_r[32:0];

      rnd_dist = 49'((prod_ff + 65'h8000) >> 16);
      dist_pos = $signed({1'b0, rnd_dist});

      sum_s    = 51'(dl_ff) + 51'(dr_ff);
      diff_s   = 51'(dr_ff) - 51'(dl_ff);
      sum_mag  = sum_s[50] ? 51'(-sum_s) : sum_s;
      diff_mag = diff_ff[50] ? 51'(-diff_ff) : diff_ff;
      diff_hi32 = {{13{diff_ff[50]}}, diff_ff[50:32]};

      rsum    = {prod_ff[43:0], 32'b0} + 76'(t0_ff) + 76'h8000;
      asum    = t0_ff[63:0] + 64'h80000000;
      ang_val = prod_ff[31:0] + asum[63:32];

      cos_abs = cos_val[32] ? 33'(-cos_val) : cos_val;
      sin_abs = sin_val[32] ? 33'(-sin_val) : sin_val;

      // position step, rounded at bit 30, then saturating add
      msum      = {prod_ff[49:0], 32'b0} + 82'(t0_ff) + 82'h20000000;
      move_mag  = msum[81:30];
      move_neg  = dneg_ff ^ ((seq_ff == SQ_XS) ? cos_val[32] : sin_val[32]);
      move_base = 54'(signed'((seq_ff == SQ_XS) ? pose_x_ff : pose_y_ff));
      move_cand = move_neg ? move_base - $signed({2'b0, move_mag})
                           : move_base + $signed({2'b0, move_mag});
      if (!move_cand[53] && move_cand[52:31] != '0) begin
         move_res = 32'h7FFFFFFF;
      end else if (move_cand[53] && move_cand[52:31] != '1) begin
         move_res = 32'h80000000;
      end else begin
         move_res = move_cand[31:0];
      end

      div_num = {prod_ff[31:0], 32'b0} + t0_ff[63:0] + 64'(int_ff >> 1);

      rate_big = (seq_ff == SQ_VD) ? (dmag_ff[49:43] != '0) : (rmag_ff[58:43] != '0);
      rate_neg = (seq_ff == SQ_VD) ? dneg_ff : rneg_ff;
      rate_sat = rate_big || div_ovf;
      if (rate_sat) begin
         rate_res = rate_neg ? 32'h80000000 : 32'h7FFFFFFF;
      end else begin
         rate_res = rate_neg ? 32'(-{1'b0, div_quot}) : {1'b0, div_quot};
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (seq_ff)
         SQ_ML: begin mul_a = mag_l; mul_b = mpt_ff; end
         SQ_MR: begin mul_a = mag_r; mul_b = mpt_ff; end
         SQ_R0: begin mul_a = 33'(diff_mag[31:0]); mul_b = 32'(inv_base_ff); end
         SQ_R1: begin mul_a = 33'(diff_mag[50:32]); mul_b = 32'(inv_base_ff); end
         SQ_W0: begin mul_a = 33'(diff_ff[31:0]); mul_b = 32'(inv_base_ff); end
         SQ_W1: begin mul_a = 33'(diff_hi32); mul_b = 32'(inv_base_ff); end
         SQ_A0: begin mul_a = 33'(wide_ff[31:0]); mul_b = ANG_SCALE; end
         SQ_A1: begin mul_a = 33'(wide_ff[63:32]); mul_b = ANG_SCALE; end
         SQ_H0: begin mul_a = 33'(wide_ff[31:0]); mul_b = ANG_HALF; end
         SQ_H1: begin mul_a = 33'(wide_ff[63:32]); mul_b = ANG_HALF; end
         SQ_X0: begin mul_a = 33'(dmag_ff[31:0]); mul_b = cos_abs[31:0]; end
         SQ_X1: begin mul_a = 33'(dmag_ff[49:32]); mul_b = cos_abs[31:0]; end
         SQ_XS: begin mul_a = 33'(dmag_ff[31:0]); mul_b = sin_abs[31:0]; end
         SQ_Y1: begin mul_a = 33'(dmag_ff[49:32]); mul_b = sin_abs[31:0]; end
         SQ_YS: begin mul_a = 33'(dmag_ff[31:0]); mul_b = US_PER_S; end
         SQ_V1: begin mul_a = 33'(dmag_ff[42:32]); mul_b = US_PER_S; end
         SQ_G0: begin mul_a = 33'(rmag_ff[31:0]); mul_b = US_PER_S; end
         SQ_G1: begin mul_a = 33'(rmag_ff[42:32]); mul_b = US_PER_S; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign cordic_start = (state_ff == ST_CALC) && (seq_ff == SQ_HS);
   assign div_start    = (state_ff == ST_CALC) && (seq_ff == SQ_VD || seq_ff == SQ_GD);

   // sequencer
   always_comb begin
      state_in = state_ff;
      seq_in   = seq_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (!base_valid_ff || reject) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_CALC;
                  seq_in   = SQ_ML;
               end
            end
         end
         ST_CALC: begin
            if (seq_ff == SQ_HS) begin
               state_in = ST_CORDIC;
            end else if (seq_ff == SQ_VD || seq_ff == SQ_GD) begin
               state_in = ST_DIV;
            end else begin
               seq_in = seq_ff + 5'd1;
            end
         end
         ST_CORDIC: begin
            if (cordic_done) begin
               state_in = ST_CALC;
               seq_in   = SQ_X0;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (seq_ff == SQ_VD) begin
                  state_in = ST_CALC;
                  seq_in   = SQ_G0;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         seq_ff        <= SQ_ML;
         rsp_valid_ff  <= 1'b0;
         mpt_ff        <= RST_METRES_PER_TICK;
         inv_base_ff   <= RST_INV_WHEEL_BASE;
         left_neg_ff   <= 1'b1;
         right_neg_ff  <= 1'b0;
         max_int_ff    <= RST_MAX_INTERVAL;
         left_base_ff  <= '0;
         right_base_ff <= '0;
         base_valid_ff <= 1'b0;
         pose_x_ff     <= '0;
         pose_y_ff     <= '0;
         pose_h_ff     <= '0;
      end else begin
         state_ff <= state_in;
         seq_ff   <= seq_in;

         if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_chan.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_write_en) begin
            unique case (csr_index)
               CSR_METRES_PER_TICK: mpt_ff       <= csr_wdata;
               CSR_INV_WHEEL_BASE:  inv_base_ff  <= csr_wdata[23:0];
               CSR_LEFT_NEG:        left_neg_ff  <= csr_wdata[0];
               CSR_RIGHT_NEG:       right_neg_ff <= csr_wdata[0];
               CSR_MAX_INTERVAL:    max_int_ff   <= csr_wdata[INTERVAL_W-1:0];
               default: ;
            endcase
         end

         if (state_ff == ST_IDLE && req_chan.valid && !base_valid_ff) begin
            left_base_ff  <= lc_in;
            right_base_ff <= rc_in;
            base_valid_ff <= 1'b1;
         end
         if (state_ff == ST_CALC) begin
            if (seq_ff == SQ_SD) begin
               left_base_ff  <= lc_ff;
               right_base_ff <= rc_ff;
            end
            if (seq_ff == SQ_XS) begin
               pose_x_ff <= move_res;
            end
            if (seq_ff == SQ_YS) begin
               pose_y_ff <= move_res;
               pose_h_ff <= pose_h_ff + hstep_ff;
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;

      if (state_ff == ST_IDLE && req_chan.valid) begin
         lc_ff  <= lc_in;
         rc_ff  <= rc_in;
         int_ff <= req_chan.interval_us;
         lin_ff <= '0;
         ang_ff <= '0;
         if (!base_valid_ff) begin
            status_ff <= STATUS_BASELINE;
         end else if (reject) begin
            status_ff <= STATUS_REJECTED;
         end else begin
            status_ff <= STATUS_UPDATED;
         end
      end

      if (state_ff == ST_CALC) begin
         unique case (seq_ff)
            SQ_MR: dl_ff <= dlt_l[33] ? -dist_pos : dist_pos;
            SQ_DR: dr_ff <= dlt_r[33] ? -dist_pos : dist_pos;
            SQ_SD: begin
               dmag_ff <= 50'((52'(sum_mag) + 52'd1) >> 1);
               dneg_ff <= sum_s[50];
               diff_ff <= diff_s;
            end
            SQ_R1, SQ_W1, SQ_A1, SQ_H1, SQ_X1, SQ_Y1, SQ_V1, SQ_G1: t0_ff <= prod_ff;
            SQ_W0: begin
               rmag_ff <= rsum[74:16];
               rneg_ff <= diff_ff[50];
            end
            SQ_WS: wide_ff  <= t0_ff[63:0] + {prod_ff[31:0], 32'b0};
            SQ_H0: hstep_ff <= ang_val;
            default: ;
         endcase
      end

      if (state_ff == ST_DIV && div_done) begin
         if (seq_ff == SQ_VD) begin
            lin_ff <= rate_res;
         end else begin
            ang_ff <= rate_res;
         end
      end

      if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_chan.ready)) begin
         out_status_ff <= status_ff;
         out_x_ff      <= pose_x_ff;
         out_y_ff      <= pose_y_ff;
         out_h_ff      <= pose_h_ff;
         out_lin_ff    <= lin_ff;
         out_ang_ff    <= ang_ff;
      end
   end

   assign req_chan.ready            = (state_ff == ST_IDLE);
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = out_status_ff;
   assign rsp_chan.pos_x            = out_x_ff;
   assign rsp_chan.pos_y            = out_y_ff;
   assign rsp_chan.heading_angle    = out_h_ff;
   assign rsp_chan.linear_velocity  = out_lin_ff;
   assign rsp_chan.angular_velocity = out_ang_ff;

endmodule
